FILE: src/integer_to_ascii_formatter_unit_assert.svh
// Assertion macros used by the checker file ita_checker.
`ifndef INTEGER_TO_ASCII_FORMATTER_UNIT_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ITA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ita assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ITA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ita assertion failed");

`endif

FILE: src/ita_pkg.sv
package ita_pkg;

  localparam int unsigned ITA_NDIG  = 10;            // decimal digits of a 32-bit value
  localparam int unsigned ITA_BCD_W = 4 * ITA_NDIG;

  localparam logic [5:0] ITA_MAX_WIDTH = 6'd62;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_X     = 8'h78;

  typedef enum logic [2:0] {
    CMD_SDEC = 3'd0,
    CMD_UDEC = 3'd1,
    CMD_HEX  = 3'd2,
    CMD_PTR  = 3'd3,
    CMD_CHAR = 3'd4
  } ita_cmd_e;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_DABBLE,
    CV_NORM,
    CV_DONE
  } ita_conv_st_e;

  typedef enum logic [2:0] {
    EM_IDLE,
    EM_PFX0,
    EM_PFX1,
    EM_SIGN,
    EM_PAD,
    EM_DIG,
    EM_CHR
  } ita_emit_st_e;

  // Converted request handed from the converter to the character sequencer.
  typedef struct packed {
    ita_cmd_e               cmd;
    logic                   neg;
    logic [5:0]             wid;
    logic [3:0]             ndig;   // significant digits, digits left-aligned
    logic [ITA_BCD_W-1:0]   digits; // char kind: character in low byte
  } ita_job_t;

  function automatic logic [7:0] ita_hex_char(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = CH_ZERO + {4'd0, d};
    end else begin
      r = CH_LOW_A + {4'd0, d} - 8'd10;
    end
    return r;
  endfunction

endpackage

FILE: src/integer_to_ascii_formatter_unit.sv
// Integer to ASCII formatter (printf-style %d %u %x %p %c; zero padded, %c with spaces).
// Slave stream: one request per word; tuser = command, tdata = value and field width.
// Master stream: one ASCII character per word, leftmost first; tlast marks the final
// character of a request. Commands 5..7 are taken and produce nothing.
// Two stages: a converter turns the value into digits (decimal: bit-serial BCD, one bit
// a cycle; decimal and hex: then strips leading zero digits one a cycle) and a sequencer
// sends characters one a cycle while the master side takes them. The converter takes a
// new request while the sequencer still sends the last one. Converter path: decimal
// runs dabble, strip, done; hex runs strip, done; character goes straight to done.
// The sequencer loads a ready job into its state registers when idle, then registers
// each character in the output register. A request occupies the output for its
// characters (up to 64), the sequencer passes its idle state between requests, and the
// converter's dabble and strip passes can set a floor on the time per request.
// Reset clears both stages and the output valid; no clearing pass is needed.
// A stall on the master side holds the output word; the sequencer then waits and the
// converter fills and holds its result, and the slave side keeps tready low meanwhile.
module integer_to_ascii_formatter_unit #(
  parameter logic [5:0] MAX_WIDTH = ita_pkg::ITA_MAX_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // [31:0] value, [37:32] width, [39:38] zero
  input  logic [2:0]  s_axis_tuser_i,  // [2:0] command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // [7:0] out_char
  output logic        m_axis_tlast_o
);

  ita_pkg::ita_job_t job;
  logic              job_valid;
  logic              job_ready;

  ita_conv #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .cmd_i       (s_axis_tuser_i),
    .value_i     (s_axis_tdata_i[31:0]),
    .wid_i       (s_axis_tdata_i[37:32]),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  ita_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

FILE: src/ita_conv.sv
// Bit-serial binary to BCD (shift and add 3) for decimal, then leading-zero strip one digit a cycle.
module ita_conv #(
  parameter logic [5:0] MAX_WIDTH = ita_pkg::ITA_MAX_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           cmd_i,
  input  logic [31:0]          value_i,
  input  logic [5:0]           wid_i,
  output logic                 job_valid_o,
  input  logic                 job_ready_i,
  output ita_pkg::ita_job_t    job_o
);

  localparam int unsigned BW = ita_pkg::ITA_BCD_W;

  ita_pkg::ita_conv_st_e state_q, state_d;
  ita_pkg::ita_cmd_e     cmd_q, cmd_d, cmd_in;
  logic                  neg_q, neg_d, neg_in;
  logic [5:0]            wid_q, wid_d;
  logic [31:0]           bin_q, bin_d;
  logic [BW-1:0]         bcd_q, bcd_d, bcd_adj;
  logic [4:0]            bitcnt_q, bitcnt_d;
  logic [3:0]            ndig_q, ndig_d;
  logic                  norm_done;

  assign cmd_in    = ita_pkg::ita_cmd_e'(cmd_i);
  assign neg_in    = (cmd_in == ita_pkg::CMD_SDEC) && value_i[31];
  assign norm_done = (ndig_q == 4'd1) || (bcd_q[BW-1 -: 4] != 4'd0);

  always_comb begin
    bcd_adj = bcd_q;
    for (int i = 0; i < ita_pkg::ITA_NDIG; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ita_pkg::CV_IDLE: begin
        if (in_valid_i) begin
          case (cmd_in)
            ita_pkg::CMD_SDEC, ita_pkg::CMD_UDEC: state_d = ita_pkg::CV_DABBLE;
            ita_pkg::CMD_HEX, ita_pkg::CMD_PTR:   state_d = ita_pkg::CV_NORM;
            ita_pkg::CMD_CHAR:                    state_d = ita_pkg::CV_DONE;
            default:                              state_d = ita_pkg::CV_IDLE;
          endcase
        end
      end
      ita_pkg::CV_DABBLE: begin
        if (bitcnt_q == 5'd0) state_d = ita_pkg::CV_NORM;
      end
      ita_pkg::CV_NORM: begin
        if (norm_done) state_d = ita_pkg::CV_DONE;
      end
      ita_pkg::CV_DONE: begin
        if (job_ready_i) state_d = ita_pkg::CV_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = (state_q == ita_pkg::CV_IDLE);
    job_valid_o = (state_q == ita_pkg::CV_DONE);
    job_o.cmd    = cmd_q;
    job_o.neg    = neg_q;
    job_o.wid    = wid_q;
    job_o.ndig   = ndig_q;
    job_o.digits = bcd_q;
  end

  // datapath
  always_comb begin
    cmd_d    = cmd_q;
    neg_d    = neg_q;
    wid_d    = wid_q;
    bin_d    = bin_q;
    bcd_d    = bcd_q;
    bitcnt_d = bitcnt_q;
    ndig_d   = ndig_q;
    unique case (state_q)
      ita_pkg::CV_IDLE: begin
        if (in_valid_i) begin
          cmd_d    = cmd_in;
          neg_d    = neg_in;
          wid_d    = (wid_i > MAX_WIDTH) ? MAX_WIDTH : wid_i;
          bin_d    = neg_in ? (~value_i + 32'd1) : value_i;
          bitcnt_d = 5'd31;
          ndig_d   = 4'(ita_pkg::ITA_NDIG);
          if (cmd_in == ita_pkg::CMD_HEX || cmd_in == ita_pkg::CMD_PTR) begin
            bcd_d = {{(BW-32){1'b0}}, value_i};
          end else if (cmd_in == ita_pkg::CMD_CHAR) begin
            bcd_d = {{(BW-8){1'b0}}, value_i[7:0]};
          end else begin
            bcd_d = '0;
          end
        end
      end
      ita_pkg::CV_DABBLE: begin
        bcd_d    = {bcd_adj[BW-2:0], bin_q[31]};
        bin_d    = {bin_q[30:0], 1'b0};
        bitcnt_d = bitcnt_q - 5'd1;
      end
      ita_pkg::CV_NORM: begin
        if (!norm_done) begin
          bcd_d  = {bcd_q[BW-5:0], 4'd0};
          ndig_d = ndig_q - 4'd1;
        end
      end
      ita_pkg::CV_DONE: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ita_pkg::CV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    neg_q    <= neg_d;
    wid_q    <= wid_d;
    bin_q    <= bin_d;
    bcd_q    <= bcd_d;
    bitcnt_q <= bitcnt_d;
    ndig_q   <= ndig_d;
  end

endmodule

FILE: src/ita_emit.sv
// Sequencer: prefix, sign, pad, digits or char, to output reg one a cycle unless stalled.
module ita_emit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  output logic                 job_ready_o,
  input  ita_pkg::ita_job_t    job_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_char_o,
  output logic                 out_last_o
);

  localparam int unsigned BW = ita_pkg::ITA_BCD_W;

  ita_pkg::ita_emit_st_e state_q, state_d;
  logic [BW-1:0] dig_q, dig_d;
  logic [3:0]    nd_q, nd_d;
  logic [5:0]    cnt_q, cnt_d;
  logic          is_char_q, is_char_d;
  logic          valid_q, valid_d;
  logic [7:0]    data_q, ch;
  logic          last_q, last_w;
  logic          out_free, step;
  logic [5:0]    used, pad_num, pad_chr, pad_ld;

  assign out_free = !valid_q || out_ready_i;
  assign used     = {2'd0, job_i.ndig} + {5'd0, job_i.neg};
  assign pad_num  = (job_i.wid > used) ? (job_i.wid - used) : 6'd0;
  assign pad_chr  = (job_i.wid > 6'd1) ? (job_i.wid - 6'd1) : 6'd0;
  assign pad_ld   = (job_i.cmd == ita_pkg::CMD_CHAR) ? pad_chr : pad_num;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ita_pkg::EM_IDLE: begin
        if (job_valid_i) begin
          case (job_i.cmd)
            ita_pkg::CMD_CHAR: state_d = (pad_chr != 6'd0) ? ita_pkg::EM_PAD : ita_pkg::EM_CHR;
            ita_pkg::CMD_PTR:  state_d = ita_pkg::EM_PFX0;
            default: begin
              if (job_i.neg)              state_d = ita_pkg::EM_SIGN;
              else if (pad_num != 6'd0)   state_d = ita_pkg::EM_PAD;
              else                        state_d = ita_pkg::EM_DIG;
            end
          endcase
        end
      end
      ita_pkg::EM_PFX0: begin
        if (out_free) state_d = ita_pkg::EM_PFX1;
      end
      ita_pkg::EM_PFX1, ita_pkg::EM_SIGN: begin
        if (out_free) state_d = (cnt_q != 6'd0) ? ita_pkg::EM_PAD : ita_pkg::EM_DIG;
      end
      ita_pkg::EM_PAD: begin
        if (out_free && cnt_q == 6'd1) begin
          state_d = is_char_q ? ita_pkg::EM_CHR : ita_pkg::EM_DIG;
        end
      end
      ita_pkg::EM_DIG: begin
        if (out_free && nd_q == 4'd1) state_d = ita_pkg::EM_IDLE;
      end
      ita_pkg::EM_CHR: begin
        if (out_free) state_d = ita_pkg::EM_IDLE;
      end
      default: state_d = ita_pkg::EM_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    job_ready_o = (state_q == ita_pkg::EM_IDLE);
    step        = (state_q != ita_pkg::EM_IDLE) && out_free;
    ch          = ita_pkg::CH_ZERO;
    last_w      = 1'b0;
    unique case (state_q)
      ita_pkg::EM_IDLE: ch = ita_pkg::CH_ZERO;
      ita_pkg::EM_PFX0: ch = ita_pkg::CH_ZERO;
      ita_pkg::EM_PFX1: ch = ita_pkg::CH_X;
      ita_pkg::EM_SIGN: ch = ita_pkg::CH_MINUS;
      ita_pkg::EM_PAD:  ch = is_char_q ? ita_pkg::CH_SPACE : ita_pkg::CH_ZERO;
      ita_pkg::EM_DIG: begin
        ch     = ita_pkg::ita_hex_char(dig_q[BW-1 -: 4]);
        last_w = (nd_q == 4'd1);
      end
      ita_pkg::EM_CHR: begin
        ch     = dig_q[7:0];
        last_w = 1'b1;
      end
      default: ch = ita_pkg::CH_ZERO;
    endcase
  end

  // datapath
  always_comb begin
    dig_d     = dig_q;
    nd_d      = nd_q;
    cnt_d     = cnt_q;
    is_char_d = is_char_q;
    valid_d   = step ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);
    if (state_q == ita_pkg::EM_IDLE && job_valid_i) begin
      dig_d     = job_i.digits;
      nd_d      = job_i.ndig;
      cnt_d     = pad_ld;
      is_char_d = (job_i.cmd == ita_pkg::CMD_CHAR);
    end else if (step && state_q == ita_pkg::EM_PAD) begin
      cnt_d = cnt_q - 6'd1;
    end else if (step && state_q == ita_pkg::EM_DIG) begin
      dig_d = {dig_q[BW-5:0], 4'd0};
      nd_d  = nd_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ita_pkg::EM_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q     <= dig_d;
    nd_q      <= nd_d;
    cnt_q     <= cnt_d;
    is_char_q <= is_char_d;
    if (step) begin
      data_q <= ch;
      last_q <= last_w;
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = data_q;
  assign out_last_o  = last_q;

endmodule

FILE: src/ita_checker.sv
`include "integer_to_ascii_formatter_unit_assert.svh"

module ita_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [2:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  logic s_take;
  logic bad_cmd;
  logic out_stall;

  assign s_take    = s_axis_tvalid_i && s_axis_tready_o;
  assign bad_cmd   = (s_axis_tuser_i > ita_pkg::CMD_CHAR);
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;

  `ITA_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid_o)
  `ITA_ASSERT_NEXT(a_out_stable, out_stall, $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
  `ITA_ASSERT_NEXT(a_busy_after_take, s_take && !bad_cmd, !s_axis_tready_o)
  `ITA_ASSERT_NEXT(a_drop_bad_cmd, s_take && bad_cmd, s_axis_tready_o)

endmodule

bind integer_to_ascii_formatter_unit ita_checker u_ita_checker (.*);
